// ===== rtl/abeds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package abeds_pkg;

  // Output vector and score widths, and the balance width
  localparam int unsigned VEC_W   = 64;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned BAL_W   = 16;

  // Operation codes carried on the operation field
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_LOAD_A  = 2'd1,
    OP_LOAD_B  = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  // One result transfer
  typedef struct packed {
    logic               moved_down;
    logic [SCORE_W-1:0] score;
    logic [VEC_W-1:0]   horiz_plus;
    logic [VEC_W-1:0]   horiz_minus;
    logic [VEC_W-1:0]   vert_plus;
    logic [VEC_W-1:0]   vert_minus;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/adaptive_band_edit_distance_step_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Banded bit-parallel edit-distance step.
// Input channel (in_valid / in_stall) carries one operation per transfer:
// start, preload an a base, preload a b base, or advance the band. Every
// accepted item yields exactly one result on the output channel
// (out_valid / out_stall): the move direction, the centre score and the four
// difference vectors, zero-extended to 64 bits when BAND_WIDTH is below 64.
// A transfer into a free output register shows on out_valid in the next cycle.
// The band state is updated in the cycle of acceptance, so one item is taken
// every cycle while in_stall is low. The result register is backed by a
// one-entry skid register: when the receiver stalls, one further item is
// still taken into the skid stage, and in_stall then rises until the output
// drains. in_stall comes straight from the skid register and does not depend
// on out_stall combinationally. Reset (rst, synchronous) clears both output
// stages and puts the windows, vectors, score and balance to their start values;
// a start operation does the same to the band state and also produces a result.
module adaptive_band_edit_distance_step_top #(
  parameter int unsigned BAND_WIDTH = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  abeds_pkg::op_t               operation,
  input  wire  [1:0]                   a_base,
  input  wire  [1:0]                   b_base,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         moved_down,
  output logic signed [abeds_pkg::SCORE_W-1:0] score_out,
  output logic [abeds_pkg::VEC_W-1:0]  out_horiz_plus,
  output logic [abeds_pkg::VEC_W-1:0]  out_horiz_minus,
  output logic [abeds_pkg::VEC_W-1:0]  out_vert_plus,
  output logic [abeds_pkg::VEC_W-1:0]  out_vert_minus
);
  import abeds_pkg::*;

  localparam int unsigned BW = BAND_WIDTH;
  localparam int unsigned H  = BAND_WIDTH / 2;

  localparam logic [BW-1:0] ONES   = {BW{1'b1}};
  localparam logic [BW-1:0] HP_RST = {{(BW-H){1'b0}}, {H{1'b1}}};
  localparam logic [BW-1:0] HM_RST = {{(BW-H){1'b1}}, {H{1'b0}}};
  localparam logic [BW-1:0] VP_RST = {{(BW-H-1){1'b1}}, {(H+1){1'b0}}};
  localparam logic [BW-1:0] VM_RST = {{(BW-H-1){1'b0}}, {(H+1){1'b1}}};

  localparam logic signed [BAL_W:0] BAL_MAX = (BAL_W+1)'(32767);
  localparam logic signed [BAL_W:0] BAL_MIN = -(BAL_W+1)'(32768);
  localparam logic signed [BAL_W-1:0] BAL_RST = -BAL_W'(2);

  // Band state
  logic [BW-1:0]            a_lo, a_hi, b_lo, b_hi;
  logic [BW-1:0]            hp, hm, vp, vm;
  logic [SCORE_W-1:0]       score;
  logic signed [BAL_W-1:0]  balance;

  logic [BW-1:0]            a_lo_next, a_hi_next, b_lo_next, b_hi_next;
  logic [BW-1:0]            hp_next, hm_next, vp_next, vm_next;
  logic [SCORE_W-1:0]       score_next;
  logic signed [BAL_W-1:0]  balance_next;
  logic                     down_next;

  // Step datapath
  logic [BW-1:0]            a_lo_sh, a_hi_sh, b_lo_sh, b_hi_sh;
  logic [BW-1:0]            hp_sh, hm_sh, vp_sh, vm_sh;
  logic [BW-1:0]            eq, xh, xv, nph, npv, nmh, nmv, p_vec, m_vec;
  logic                     go_down;
  logic signed [BAL_W:0]    bal_sum;
  logic signed [BAL_W-1:0]  bal_sat;
  logic [SCORE_W-1:0]       score_adv;

  // Output stages
  result_t                  out_r, skid_r, new_res;
  logic                     skid_valid;
  logic                     accept, out_free;

  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = skid_valid;

  // Shift windows and vectors for the chosen move
  always_comb begin
    go_down = balance[BAL_W-1];
    a_lo_sh = {a_lo[BW-2:0], a_base[0]};
    a_hi_sh = {a_hi[BW-2:0], a_base[1]};
    b_lo_sh = {b_base[0], b_lo[BW-1:1]};
    b_hi_sh = {b_base[1], b_hi[BW-1:1]};
    if (go_down) begin
      hp_sh = hp;
      hm_sh = hm;
      vp_sh = {1'b1, vp[BW-1:1]};
      vm_sh = {1'b0, vm[BW-1:1]};
    end else begin
      hp_sh = {hp[BW-2:0], 1'b1};
      hm_sh = {hm[BW-2:0], 1'b0};
      vp_sh = vp;
      vm_sh = vm;
    end
  end

  // Recompute difference vectors from the match mask
  always_comb begin
    if (go_down) begin
      eq = ~((a_lo ^ b_lo_sh) | (a_hi ^ b_hi_sh));
    end else begin
      eq = ~((a_lo_sh ^ b_lo) | (a_hi_sh ^ b_hi));
    end
    xh  = eq | hm_sh;
    xv  = eq | vm_sh;
    nph = vm_sh | ~(xh | vp_sh);
    npv = hm_sh | ~(xv | hp_sh);
    nmh = vp_sh & xh;
    nmv = hp_sh & xv;
    p_vec = go_down ? npv : nph;
    m_vec = go_down ? nmv : nmh;
  end

  // Update balance (saturating) and centre score
  always_comb begin
    bal_sum = (BAL_W+1)'(balance)
            + (BAL_W+1)'(p_vec[BW-1]) - (BAL_W+1)'(p_vec[0])
            - (BAL_W+1)'(m_vec[BW-1]) + (BAL_W+1)'(m_vec[0]);
    if (bal_sum > BAL_MAX) begin
      bal_sat = BAL_W'(BAL_MAX);
    end else if (bal_sum < BAL_MIN) begin
      bal_sat = BAL_W'(BAL_MIN);
    end else begin
      bal_sat = bal_sum[BAL_W-1:0];
    end
    score_adv = score + SCORE_W'(p_vec[H]) - SCORE_W'(m_vec[H]);
  end

  // Select next band state by operation
  always_comb begin
    a_lo_next    = a_lo;
    a_hi_next    = a_hi;
    b_lo_next    = b_lo;
    b_hi_next    = b_hi;
    hp_next      = hp;
    hm_next      = hm;
    vp_next      = vp;
    vm_next      = vm;
    score_next   = score;
    balance_next = balance;
    down_next    = 1'b0;
    case (operation)
      OP_START: begin
        a_lo_next    = '0;
        a_hi_next    = '0;
        b_lo_next    = ONES;
        b_hi_next    = ONES;
        hp_next      = HP_RST;
        hm_next      = HM_RST;
        vp_next      = VP_RST;
        vm_next      = VM_RST;
        score_next   = '0;
        balance_next = BAL_RST;
      end
      OP_LOAD_A: begin
        a_lo_next = a_lo_sh;
        a_hi_next = a_hi_sh;
      end
      OP_LOAD_B: begin
        b_lo_next = b_lo_sh;
        b_hi_next = b_hi_sh;
      end
      OP_ADVANCE: begin
        down_next = go_down;
        if (go_down) begin
          b_lo_next = b_lo_sh;
          b_hi_next = b_hi_sh;
        end else begin
          a_lo_next = a_lo_sh;
          a_hi_next = a_hi_sh;
        end
        // All four vectors take their recomputed values on either move
        hp_next      = nph;
        hm_next      = nmh;
        vp_next      = npv;
        vm_next      = nmv;
        score_next   = score_adv;
        balance_next = bal_sat;
      end
      default: begin
        down_next = 1'b0;
      end
    endcase
  end

  // Assemble the result of this transfer
  always_comb begin
    new_res.moved_down  = down_next;
    new_res.score       = score_next;
    new_res.horiz_plus  = VEC_W'(hp_next);
    new_res.horiz_minus = VEC_W'(hm_next);
    new_res.vert_plus   = VEC_W'(vp_next);
    new_res.vert_minus  = VEC_W'(vm_next);
  end

  // Advance band state on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      a_lo    <= '0;
      a_hi    <= '0;
      b_lo    <= ONES;
      b_hi    <= ONES;
      hp      <= HP_RST;
      hm      <= HM_RST;
      vp      <= VP_RST;
      vm      <= VM_RST;
      score   <= '0;
      balance <= BAL_RST;
    end else if (accept) begin
      a_lo    <= a_lo_next;
      a_hi    <= a_hi_next;
      b_lo    <= b_lo_next;
      b_hi    <= b_hi_next;
      hp      <= hp_next;
      hm      <= hm_next;
      vp      <= vp_next;
      vm      <= vm_next;
      score   <= score_next;
      balance <= balance_next;
    end
  end

  // Output register with skid stage: drain skid first, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= new_res;
      end
    end else if (accept) begin
      skid_r <= new_res;
    end
  end

  assign moved_down      = out_r.moved_down;
  assign score_out       = $signed(out_r.score);
  assign out_horiz_plus  = out_r.horiz_plus;
  assign out_horiz_minus = out_r.horiz_minus;
  assign out_vert_plus   = out_r.vert_plus;
  assign out_vert_minus  = out_r.vert_minus;

endmodule

`default_nettype wire

// ===== rtl/abeds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module abeds_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_stall,
  input abeds_pkg::op_t               operation,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire                          moved_down,
  input wire [abeds_pkg::SCORE_W-1:0] score_out,
  input wire [abeds_pkg::VEC_W-1:0]   out_horiz_plus
);
  import abeds_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(score_out) && $stable(out_horiz_plus))
    else $error("stalled result changed");

  // Input stall only rises after the output stalled with a result waiting
  assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A transfer into a free output shows next cycle; only advances move down
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (!out_valid || !out_stall) |=>
      out_valid && ($past(operation) == OP_ADVANCE || !moved_down))
    else $error("result missing or wrong move flag");

  // A start transfer returns the score to zero
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (!out_valid || !out_stall) && operation == OP_START |=>
      score_out == '0)
    else $error("start did not clear the score");

endmodule

bind adaptive_band_edit_distance_step_top abeds_checker u_abeds_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .operation      (operation),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .moved_down     (moved_down),
  .score_out      (score_out),
  .out_horiz_plus (out_horiz_plus)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import abeds_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 40;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  op_t              operation = OP_START;
  logic [1:0]       a_base = 2'd0;
  logic [1:0]       b_base = 2'd0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             moved_down;
  logic signed [SCORE_W-1:0] score_out;
  logic [VEC_W-1:0] out_horiz_plus;
  logic [VEC_W-1:0] out_horiz_minus;
  logic [VEC_W-1:0] out_vert_plus;
  logic [VEC_W-1:0] out_vert_minus;

  // Band predictor state
  logic [VEC_W-1:0]   band_a_lo, band_a_hi, band_b_lo, band_b_hi;
  logic [VEC_W-1:0]   band_hp, band_hm, band_vp, band_vm;
  logic [SCORE_W-1:0] band_score;
  int                 band_balance;
  logic               last_down;

  result_t pending_results[$];
  int      error_count = 0;
  int      sent_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_request = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  adaptive_band_edit_distance_step_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .a_base          (a_base),
    .b_base          (b_base),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .moved_down      (moved_down),
    .score_out       (score_out),
    .out_horiz_plus  (out_horiz_plus),
    .out_horiz_minus (out_horiz_minus),
    .out_vert_plus   (out_vert_plus),
    .out_vert_minus  (out_vert_minus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Return the band to its start position
  function automatic void band_clear();
    band_a_lo    = '0;
    band_a_hi    = '0;
    band_b_lo    = '1;
    band_b_hi    = '1;
    band_hp      = 64'h0000_0000_FFFF_FFFF;
    band_hm      = 64'hFFFF_FFFF_0000_0000;
    band_vp      = 64'hFFFF_FFFE_0000_0000;
    band_vm      = 64'h0000_0001_FFFF_FFFF;
    band_score   = '0;
    band_balance = -2;
  endfunction

  // a enters at the low end, b at the top end
  function automatic void band_push_a(logic [1:0] base);
    band_a_lo = {band_a_lo[VEC_W-2:0], base[0]};
    band_a_hi = {band_a_hi[VEC_W-2:0], base[1]};
  endfunction

  function automatic void band_push_b(logic [1:0] base);
    band_b_lo = {base[0], band_b_lo[VEC_W-1:1]};
    band_b_hi = {base[1], band_b_hi[VEC_W-1:1]};
  endfunction

  // Rebuild the difference vectors from the match mask
  function automatic void band_recompute();
    logic [VEC_W-1:0] eq, xh, xv, nph, npv, nmh, nmv;
    eq  = ~((band_a_lo ^ band_b_lo) | (band_a_hi ^ band_b_hi));
    xh  = eq | band_hm;
    xv  = eq | band_vm;
    nph = band_vm | ~(xh | band_vp);
    npv = band_hm | ~(xv | band_hp);
    nmh = band_vp & xh;
    nmv = band_hp & xv;
    band_hp = nph;
    band_hm = nmh;
    band_vp = npv;
    band_vm = nmv;
  endfunction

  // Update balance (saturating) and centre score (wrapping)
  function automatic void band_tally(logic [VEC_W-1:0] p, logic [VEC_W-1:0] m);
    int d;
    d = int'(p[VEC_W-1]) - int'(p[0]) - int'(m[VEC_W-1]) + int'(m[0]);
    band_balance = band_balance + d;
    if (band_balance > 32767) band_balance = 32767;
    if (band_balance < -32768) band_balance = -32768;
    band_score = band_score + p[VEC_W/2] - m[VEC_W/2];
  endfunction

  // Work out the result of one accepted item
  function automatic result_t band_step(op_t op, logic [1:0] a, logic [1:0] b);
    result_t r;
    r.moved_down = 1'b0;
    case (op)
      OP_START:  band_clear();
      OP_LOAD_A: band_push_a(a);
      OP_LOAD_B: band_push_b(b);
      default: begin
        if (band_balance < 0) begin
          r.moved_down = 1'b1;
          band_push_b(b);
          band_vp = {1'b1, band_vp[VEC_W-1:1]};
          band_vm = band_vm >> 1;
          band_recompute();
          band_tally(band_vp, band_vm);
        end else begin
          band_push_a(a);
          band_hp = {band_hp[VEC_W-2:0], 1'b1};
          band_hm = band_hm << 1;
          band_recompute();
          band_tally(band_hp, band_hm);
        end
      end
    endcase
    r.score       = band_score;
    r.horiz_plus  = band_hp;
    r.horiz_minus = band_hm;
    r.vert_plus   = band_vp;
    r.vert_minus  = band_vm;
    last_down     = r.moved_down;
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then record its result
  task automatic send_item(input op_t op, input logic [1:0] a, input logic [1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    a_base    <= a;
    b_base    <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(band_step(op, a, b));
    sent_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= PRINT_CAP)
        $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Receiver: random stall or a long hold-off, and result checking
  always @(posedge clk) begin
    result_t want;
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= PRINT_CAP)
          $display("%0t: result with nothing expected, actual score %h", $time, score_out);
      end else begin
        want = pending_results.pop_front();
        check_field("moved_down", 64'(want.moved_down), 64'(moved_down));
        check_field("score_out", 64'(want.score), 64'(score_out[SCORE_W-1:0]));
        check_field("out_horiz_plus", want.horiz_plus, out_horiz_plus);
        check_field("out_horiz_minus", want.horiz_minus, out_horiz_minus);
        check_field("out_vert_plus", want.vert_plus, out_vert_plus);
        check_field("out_vert_minus", want.vert_minus, out_vert_minus);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Extremes of the base fields, every operation, ignored bases, restart
  task automatic test_directed();
    send_item(OP_START, 2'd3, 2'd3);
    send_item(OP_ADVANCE, 2'd0, 2'd0);
    send_item(OP_ADVANCE, 2'd3, 2'd3);
    send_item(OP_LOAD_A, 2'd0, 2'd3);
    send_item(OP_LOAD_A, 2'd3, 2'd0);
    send_item(OP_LOAD_B, 2'd3, 2'd0);
    send_item(OP_LOAD_B, 2'd0, 2'd3);
    send_item(OP_LOAD_A, 2'd1, 2'd2);
    send_item(OP_LOAD_B, 2'd2, 2'd1);
    repeat (6) send_item(OP_ADVANCE, 2'd3, 2'd0);
    send_item(OP_START, 2'd0, 2'd0);
    repeat (4) send_item(OP_ADVANCE, 2'd0, 2'd3);
    send_item(OP_ADVANCE, 2'd2, 2'd1);
    send_item(OP_ADVANCE, 2'd1, 2'd2);
  endtask

  // Align a random sequence a against a mutated copy b, padding both tails
  task automatic run_alignment();
    logic [1:0] seq_a[$];
    logic [1:0] seq_b[$];
    int         len, r, ia, ib, steps, tail;
    logic [1:0] next_a, next_b;
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(4, 30);
    for (int i = 0; i < len; i++) begin
      seq_a.push_back(2'($urandom_range(3)));
      r = $urandom_range(99);
      if (r < 70) begin
        seq_b.push_back(seq_a[i]);
      end else if (r < 82) begin
        seq_b.push_back(2'($urandom_range(3)));
      end else if (r < 90) begin
        seq_b.push_back(2'($urandom_range(3)));
        seq_b.push_back(seq_a[i]);
      end else if (r >= 96) begin
        seq_b.push_back(seq_a[i]);
      end
    end
    send_item(OP_START, 2'($urandom_range(3)), 2'($urandom_range(3)));
    ia = 0;
    ib = 0;
    repeat ($urandom_range(4)) begin
      if (ia < seq_a.size()) begin
        send_item(OP_LOAD_A, seq_a[ia], 2'($urandom_range(3)));
        ia++;
      end
    end
    repeat ($urandom_range(4)) begin
      if (ib < seq_b.size()) begin
        send_item(OP_LOAD_B, 2'($urandom_range(3)), seq_b[ib]);
        ib++;
      end
    end
    // Bound the whole walk; keep a few padded steps once both are consumed
    steps = 0;
    tail  = 0;
    while ((ia < seq_a.size() || ib < seq_b.size() || tail < 4)
           && steps < 4 * len + 16) begin
      if ($urandom_range(99) < 5) begin
        send_item(op_t'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)));
      end else begin
        next_a = (ia < seq_a.size()) ? seq_a[ia] : 2'd0;
        next_b = (ib < seq_b.size()) ? seq_b[ib] : 2'd3;
        send_item(OP_ADVANCE, next_a, next_b);
        if (last_down) ib++;
        else ia++;
      end
      if (ia >= seq_a.size() && ib >= seq_b.size()) tail++;
      steps++;
    end
  endtask

  task automatic test_alignment(input int count);
    int goal;
    goal = sent_count + count;
    while (sent_count < goal) run_alignment();
  endtask

  // Uniform operations and bases
  task automatic test_random_ops(input int count);
    repeat (count)
      send_item(op_t'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)));
  endtask

  // Receiver holds off while the sender keeps offering, filling the block
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    run_alignment();
    test_random_ops(30);
  endtask

  initial begin
    band_clear();
    last_down = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      test_alignment(330);
      test_random_ops(60);
    end
    test_backpressure();

    // Drain and allow for late extra results
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/abeds_pkg.sv
rtl/adaptive_band_edit_distance_step_top.sv
rtl/abeds_checker.sv
dv/testbench.sv
